[rtl/decay_vertex_geometry_macros.svh]
// assertion macros used by the checker file
`ifndef DECAY_VERTEX_GEOMETRY_MACROS_SVH
`define DECAY_VERTEX_GEOMETRY_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during rst
`define DVG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvg check failed");

// next-cycle implication, clocked on clk, quiet during rst
`define DVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvg check failed");

`endif

[rtl/dvg_pkg.sv]
// ----------------------------------------------------------------------------
// dvg_pkg
// Types and codes shared by the decay vertex geometry block.
// ----------------------------------------------------------------------------
package dvg_pkg;

  // item opcodes
  localparam logic [3:0] OP_PV        = 4'd0;
  localparam logic [3:0] OP_LAST_LOAD = 4'd8;
  localparam logic [3:0] OP_EVAL      = 4'd9;

  // result quantity codes
  localparam logic [3:0] Q_DXY      = 4'd0;
  localparam logic [3:0] Q_DXY_ERR  = 4'd1;
  localparam logic [3:0] Q_DZ       = 4'd2;
  localparam logic [3:0] Q_DZ_ERR   = 4'd3;
  localparam logic [3:0] Q_FD       = 4'd4;
  localparam logic [3:0] Q_FD_ERR   = 4'd5;
  localparam logic [3:0] Q_DIRA     = 4'd6;
  localparam logic [3:0] Q_IP_LAST  = 4'd10;
  localparam logic [3:0] Q_NONE     = 4'd11;

  // command kinds after classification
  localparam logic [1:0] K_LOAD      = 2'd0;
  localparam logic [1:0] K_EVAL_PASS = 2'd1;
  localparam logic [1:0] K_EVAL_FAIL = 2'd2;

  // arithmetic unit operations
  localparam logic [1:0] AR_MUL  = 2'd0;
  localparam logic [1:0] AR_DIV  = 2'd1;
  localparam logic [1:0] AR_SQRT = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } dvg_cmd_t;

  typedef struct packed {
    logic         start;
    logic [1:0]   op;
    logic [127:0] a;
    logic [63:0]  b;
  } dvg_arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } dvg_arith_rsp_t;

endpackage

[rtl/dvg_cmd_if.sv]
// ----------------------------------------------------------------------------
// dvg_cmd_if
// Input item channel: valid/ready with opcode, vector and gate flags.
// ----------------------------------------------------------------------------
interface dvg_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic               vertex_valid;
  logic               vertex_fake;
  logic               has_candidate;

  modport source (output valid, opcode, comp_x, comp_y, comp_z, vertex_valid,
                  vertex_fake, has_candidate, input ready);
  modport sink (input valid, opcode, comp_x, comp_y, comp_z, vertex_valid,
                vertex_fake, has_candidate, output ready);
endinterface

[rtl/dvg_res_if.sv]
// ----------------------------------------------------------------------------
// dvg_res_if
// Result item channel: valid/ready with quantity, value and flags.
// ----------------------------------------------------------------------------
interface dvg_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         quantity;
  logic signed [31:0] value;
  logic               bad_divide;
  logic               last;

  modport source (output valid, quantity, value, bad_divide, last, input ready);
  modport sink (input valid, quantity, value, bad_divide, last, output ready);
endinterface

[rtl/dvg_front.sv]
// ----------------------------------------------------------------------------
// dvg_front
// Accepts input items, drops unused opcodes and classifies the rest.
// ----------------------------------------------------------------------------
module dvg_front import dvg_pkg::*; (
  dvg_cmd_if.sink  cmd,
  input  logic     q_full,
  output logic     q_push,
  output dvg_cmd_t q_data
);

  logic is_load;
  logic is_eval;
  logic gate;

  assign cmd.ready = !q_full;
  assign is_load   = (cmd.opcode <= OP_LAST_LOAD);
  assign is_eval   = (cmd.opcode == OP_EVAL);
  assign gate      = cmd.vertex_valid && !cmd.vertex_fake && cmd.has_candidate;

  // unused opcodes are taken and dropped
  assign q_push = cmd.valid && !q_full && (is_load || is_eval);

  always_comb begin
    q_data.slot = cmd.opcode;
    q_data.x    = cmd.comp_x;
    q_data.y    = cmd.comp_y;
    q_data.z    = cmd.comp_z;
    if (is_load) begin
      q_data.kind = K_LOAD;
    end else if (gate) begin
      q_data.kind = K_EVAL_PASS;
    end else begin
      q_data.kind = K_EVAL_FAIL;
    end
  end

endmodule

[rtl/dvg_queue.sv]
// ----------------------------------------------------------------------------
// dvg_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module dvg_queue import dvg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dvg_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output dvg_cmd_t pop_data,
  output logic     empty
);

  dvg_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/dvg_arith.sv]
// ----------------------------------------------------------------------------
// dvg_arith
// Shared multi-cycle unit: 64x64 multiply from 32x32 partial products,
// 128/64 restoring divide and 128-bit floor square root.
// ----------------------------------------------------------------------------
module dvg_arith import dvg_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  dvg_arith_req_t req,
  output dvg_arith_rsp_t rsp
);

  logic         busy;
  logic [1:0]   op;
  logic [6:0]   cnt;
  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [127:0] acc;
  logic [66:0]  rem;
  logic [127:0] quo;
  logic [63:0]  root;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  prod;
  logic [1:0]   sh;
  logic [127:0] part;
  logic [64:0]  dsh;
  logic         dge;
  logic [64:0]  ddiff;
  logic [127:0] qn;
  logic [66:0]  ssh;
  logic [66:0]  strial;
  logic         sge;
  logic [66:0]  sdiff;
  logic         fin;

  always_comb begin
    pa     = cnt[1] ? opa[63:32] : opa[31:0];
    pb     = cnt[0] ? opb[63:32] : opb[31:0];
    prod   = pa * pb;
    sh     = {1'b0, cnt[1]} + {1'b0, cnt[0]};
    part   = {64'd0, prod} << {sh, 5'd0};
    dsh    = {rem[63:0], acc[127]};
    dge    = (dsh >= {1'b0, opb});
    ddiff  = dsh - {1'b0, opb};
    qn     = {quo[126:0], dge};
    ssh    = {rem[64:0], acc[127:126]};
    strial = {1'b0, root, 2'b01};
    sge    = (ssh >= strial);
    sdiff  = ssh - strial;
    // last iteration of the running operation
    fin    = busy && !req.start &&
             (((op == AR_MUL) && (cnt == 7'd3)) ||
              ((op == AR_DIV) && (cnt == 7'd127)) ||
              ((op == AR_SQRT) && (cnt == 7'd63)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= fin;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        opa  <= req.a[63:0];
        opb  <= req.b;
        cnt  <= 7'd0;
        rem  <= 67'd0;
        quo  <= 128'd0;
        root <= 64'd0;
        acc  <= (req.op == AR_MUL) ? 128'd0 : req.a;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        unique case (op)
          AR_MUL: begin
            acc <= acc + part;
            if (cnt == 7'd3) begin
              busy  <= 1'b0;
              rsp.p <= acc + part;
            end
          end
          AR_DIV: begin
            rem <= {3'd0, dge ? ddiff[63:0] : dsh[63:0]};
            quo <= qn;
            acc <= acc << 1;
            if (cnt == 7'd127) begin
              busy  <= 1'b0;
              // quotient saturates to 64 bits
              rsp.p <= {64'd0, (qn[127:64] != 64'd0) ? {64{1'b1}} : qn[63:0]};
            end
          end
          AR_SQRT: begin
            rem  <= sge ? sdiff : ssh;
            root <= {root[62:0], sge};
            acc  <= acc << 2;
            if (cnt == 7'd63) begin
              busy  <= 1'b0;
              rsp.p <= {64'd0, root[62:0], sge};
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

[rtl/dvg_back.sv]
// ----------------------------------------------------------------------------
// dvg_back
// Executes queued commands: vector store writes and the evaluation sequence,
// driving the shared arithmetic unit and the result register.
// ----------------------------------------------------------------------------
module dvg_back import dvg_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  dvg_cmd_t       q_head,
  output logic           q_pop,
  output dvg_arith_req_t areq,
  input  dvg_arith_rsp_t arsp,
  dvg_res_if.source      res
);

  localparam int VAL_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic signed [65:0] VMAX = (66'sd1 <<< (VAL_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] VMIN = -VMAX - 66'sd1;
  localparam logic [63:0] VMAXU = VMAX[63:0];
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DA   = 5'd1;
  localparam logic [4:0] ST_DB   = 5'd2;
  localparam logic [4:0] ST_SA   = 5'd3;
  localparam logic [4:0] ST_SB   = 5'd4;
  localparam logic [4:0] ST_DSQ  = 5'd5;
  localparam logic [4:0] ST_QSUM = 5'd6;
  localparam logic [4:0] ST_N    = 5'd7;
  localparam logic [4:0] ST_R0   = 5'd8;
  localparam logic [4:0] ST_R1C  = 5'd9;
  localparam logic [4:0] ST_R1   = 5'd10;
  localparam logic [4:0] ST_RS   = 5'd11;
  localparam logic [4:0] ST_R2   = 5'd12;
  localparam logic [4:0] ST_R3   = 5'd13;
  localparam logic [4:0] ST_R4   = 5'd14;
  localparam logic [4:0] ST_R5C  = 5'd15;
  localparam logic [4:0] ST_R5   = 5'd16;
  localparam logic [4:0] ST_MD   = 5'd17;
  localparam logic [4:0] ST_MQ   = 5'd18;
  localparam logic [4:0] ST_MC   = 5'd19;
  localparam logic [4:0] ST_A1   = 5'd20;
  localparam logic [4:0] ST_A2   = 5'd21;
  localparam logic [4:0] ST_A3   = 5'd22;
  localparam logic [4:0] ST_A4   = 5'd23;
  localparam logic [4:0] ST_I1   = 5'd24;
  localparam logic [4:0] ST_I2   = 5'd25;
  localparam logic [4:0] ST_IS   = 5'd26;
  localparam logic [4:0] ST_EMIT = 5'd27;
  localparam logic [4:0] ST_NK   = 5'd28;

  logic [31:0]  store [27];
  logic [4:0]   step;
  logic [4:0]   ret;
  logic [1:0]   i;
  logic [2:0]   k;
  logic         issued;
  logic         unit_st;

  logic signed [31:0] tmp;
  logic signed [31:0] d [3];
  logic [63:0]  s [3];
  logic [63:0]  dsq [3];
  logic [63:0]  qxy;
  logic [63:0]  q3;
  logic [127:0] nxy;
  logic [127:0] n3;
  logic [63:0]  pos;
  logic [63:0]  ng;
  logic [63:0]  qp;
  logic [63:0]  den;
  logic [63:0]  per;

  logic [3:0]   e_q;
  logic [31:0]  e_val;
  logic         e_bad;
  logic         e_last;

  logic [4:0]   rd_idx;
  logic [4:0]   ld_base;
  logic [31:0]  rd;
  logic [31:0]  rd_mag;
  logic [31:0]  d_mag;
  logic [63:0]  dm;
  logic         neg;
  logic [63:0]  m_clamp;
  logic signed [65:0] dira_v;

  function automatic logic [31:0] sat_val(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > VMAX) begin
      r = VMAX[31:0];
    end else if (v < VMIN) begin
      r = VMIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_mag(input logic [63:0] m);
    return (m > VMAXU) ? VMAXU[31:0] : m[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [65:0] sx66(input logic [31:0] v);
    return $signed({{34{v[31]}}, v});
  endfunction

  always_comb begin
    unique case (step)
      ST_DA:        rd_idx = {3'd0, i};
      ST_DB:        rd_idx = 5'd6 + {3'd0, i};
      ST_SA:        rd_idx = 5'd3 + {3'd0, i};
      ST_SB:        rd_idx = 5'd9 + {3'd0, i};
      ST_MD, ST_MQ: rd_idx = 5'd12 + ({2'd0, k} * 5'd3) + {3'd0, i};
      default:      rd_idx = 5'd0;
    endcase
  end

  assign ld_base = {1'b0, q_head.slot} * 5'd3;
  assign rd      = store[rd_idx];
  assign rd_mag  = mag32(rd);
  assign d_mag   = mag32(d[i]);
  assign neg     = (ng > pos);
  assign dm      = (pos >= ng) ? (pos - ng) : (ng - pos);
  assign m_clamp = (arsp.p[63:0] > ONE) ? ONE : arsp.p[63:0];
  assign dira_v  = neg ? -$signed({2'b00, m_clamp}) : $signed({2'b00, m_clamp});
  assign q_pop   = (step == ST_IDLE) && !q_empty;

  // operand selection for the shared unit
  always_comb begin
    unit_st = 1'b1;
    areq.op = AR_MUL;
    areq.a  = 128'd0;
    areq.b  = 64'd0;
    unique case (step) inside
      ST_SA, ST_SB, ST_MQ: begin
        areq.a = {96'd0, rd_mag};
        areq.b = {32'd0, rd_mag};
      end
      ST_DSQ: begin
        areq.a = {96'd0, d_mag};
        areq.b = {32'd0, d_mag};
      end
      ST_MD: begin
        areq.a = {96'd0, d_mag};
        areq.b = {32'd0, rd_mag};
      end
      ST_N: begin
        areq.a = {64'd0, dsq[i]};
        areq.b = s[i];
      end
      ST_R0: begin
        areq.op = AR_SQRT;
        areq.a  = {64'd0, qxy};
      end
      ST_R1: begin
        areq.op = AR_DIV;
        areq.a  = nxy;
        areq.b  = qxy;
      end
      ST_R5: begin
        areq.op = AR_DIV;
        areq.a  = n3;
        areq.b  = q3;
      end
      ST_RS: begin
        areq.op = AR_SQRT;
        areq.a  = {64'd0, arsp.p[63:0]};
      end
      ST_R3: begin
        areq.op = AR_SQRT;
        areq.a  = {64'd0, s[2]};
      end
      ST_R4: begin
        areq.op = AR_SQRT;
        areq.a  = {64'd0, q3};
      end
      ST_A1: begin
        areq.a = {64'd0, q3};
        areq.b = qp;
      end
      ST_A2: begin
        areq.op = AR_SQRT;
        areq.a  = arsp.p;
      end
      ST_A3: begin
        areq.a = {64'd0, dm};
        areq.b = ONE;
      end
      ST_A4: begin
        areq.op = AR_DIV;
        areq.a  = arsp.p;
        areq.b  = den;
      end
      ST_I1: begin
        areq.a = {64'd0, dm};
        areq.b = dm;
      end
      ST_I2: begin
        areq.op = AR_DIV;
        areq.a  = arsp.p;
        areq.b  = qp;
      end
      ST_IS: begin
        areq.op = AR_SQRT;
        areq.a  = {64'd0, per};
      end
      default: begin
        unit_st = 1'b0;
      end
    endcase
    areq.start = unit_st && !issued;
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_head.kind == K_LOAD)) begin
      store[ld_base]        <= sat_val(sx66(q_head.x));
      store[ld_base + 5'd1] <= sat_val(sx66(q_head.y));
      store[ld_base + 5'd2] <= sat_val(sx66(q_head.z));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      issued    <= 1'b0;
      i         <= 2'd0;
      k         <= 3'd0;
      res.valid <= 1'b0;
    end else begin
      // a new result item in the emit step overrides the clear
      if (res.valid && res.ready && (step != ST_EMIT)) begin
        res.valid <= 1'b0;
      end
      if (unit_st && !issued) begin
        issued <= 1'b1;
      end
      if (arsp.done) begin
        issued <= 1'b0;
      end
      unique case (step)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_head.kind == K_EVAL_PASS) begin
              i    <= 2'd0;
              step <= ST_DA;
            end else if (q_head.kind == K_EVAL_FAIL) begin
              e_q    <= Q_NONE;
              e_val  <= 32'd0;
              e_bad  <= 1'b0;
              e_last <= 1'b1;
              ret    <= ST_IDLE;
              step   <= ST_EMIT;
            end
          end
        end
        ST_DA: begin
          tmp  <= rd;
          step <= ST_DB;
        end
        ST_DB: begin
          d[i] <= sat_val(sx66(rd) - sx66(tmp));
          i    <= (i == 2'd2) ? 2'd0 : i + 2'd1;
          step <= (i == 2'd2) ? ST_SA : ST_DA;
        end
        ST_SA: begin
          if (arsp.done) begin
            s[i] <= arsp.p[63:0];
            step <= ST_SB;
          end
        end
        ST_SB: begin
          if (arsp.done) begin
            s[i] <= s[i] + arsp.p[63:0];
            i    <= (i == 2'd2) ? 2'd0 : i + 2'd1;
            step <= (i == 2'd2) ? ST_DSQ : ST_SA;
          end
        end
        ST_DSQ: begin
          if (arsp.done) begin
            dsq[i] <= arsp.p[63:0];
            i      <= (i == 2'd2) ? 2'd0 : i + 2'd1;
            if (i == 2'd2) begin
              step <= ST_QSUM;
            end
          end
        end
        ST_QSUM: begin
          qxy  <= dsq[0] + dsq[1];
          q3   <= dsq[0] + dsq[1] + dsq[2];
          step <= ST_N;
        end
        ST_N: begin
          if (arsp.done) begin
            if (i == 2'd0) begin
              nxy <= arsp.p;
            end else if (i == 2'd1) begin
              nxy <= nxy + arsp.p;
            end else begin
              n3   <= nxy + arsp.p;
              step <= ST_R0;
            end
            i <= (i == 2'd2) ? 2'd0 : i + 2'd1;
          end
        end
        ST_R0: begin
          if (arsp.done) begin
            e_q    <= Q_DXY;
            e_val  <= sat_mag(arsp.p[63:0]);
            e_bad  <= 1'b0;
            e_last <= 1'b0;
            ret    <= ST_R1C;
            step   <= ST_EMIT;
          end
        end
        ST_R1C: begin
          e_q <= Q_DXY_ERR;
          if (qxy == 64'd0) begin
            e_val  <= VMAX[31:0];
            e_bad  <= 1'b1;
            e_last <= 1'b0;
            ret    <= ST_R2;
            step   <= ST_EMIT;
          end else begin
            step <= ST_R1;
          end
        end
        ST_R1, ST_R5: begin
          if (arsp.done) begin
            step <= ST_RS;
          end
        end
        ST_RS: begin
          if (arsp.done) begin
            e_val  <= sat_mag(arsp.p[63:0]);
            e_bad  <= 1'b0;
            e_last <= 1'b0;
            ret    <= (e_q == Q_DXY_ERR) ? ST_R2 : ST_MD;
            step   <= ST_EMIT;
          end
        end
        ST_R2: begin
          e_q    <= Q_DZ;
          e_val  <= d[2];
          e_bad  <= 1'b0;
          e_last <= 1'b0;
          ret    <= ST_R3;
          step   <= ST_EMIT;
        end
        ST_R3: begin
          if (arsp.done) begin
            e_q    <= Q_DZ_ERR;
            e_val  <= sat_mag(arsp.p[63:0]);
            e_bad  <= 1'b0;
            e_last <= 1'b0;
            ret    <= ST_R4;
            step   <= ST_EMIT;
          end
        end
        ST_R4: begin
          if (arsp.done) begin
            e_q    <= Q_FD;
            e_val  <= sat_mag(arsp.p[63:0]);
            e_bad  <= 1'b0;
            e_last <= 1'b0;
            ret    <= ST_R5C;
            step   <= ST_EMIT;
          end
        end
        ST_R5C: begin
          e_q <= Q_FD_ERR;
          pos <= 64'd0;
          ng  <= 64'd0;
          qp  <= 64'd0;
          i   <= 2'd0;
          k   <= 3'd0;
          if (q3 == 64'd0) begin
            e_val  <= VMAX[31:0];
            e_bad  <= 1'b1;
            e_last <= 1'b0;
            ret    <= ST_MD;
            step   <= ST_EMIT;
          end else begin
            step <= ST_R5;
          end
        end
        ST_MD: begin
          if (arsp.done) begin
            // split the dot product by sign so it stays unsigned
            if (d[i][31] != rd[31]) begin
              ng <= ng + arsp.p[63:0];
            end else begin
              pos <= pos + arsp.p[63:0];
            end
            step <= ST_MQ;
          end
        end
        ST_MQ: begin
          if (arsp.done) begin
            qp   <= qp + arsp.p[63:0];
            i    <= (i == 2'd2) ? 2'd0 : i + 2'd1;
            step <= (i == 2'd2) ? ST_MC : ST_MD;
          end
        end
        ST_MC: begin
          if (k == 3'd0) begin
            if ((q3 == 64'd0) || (qp == 64'd0)) begin
              e_q    <= Q_DIRA;
              e_val  <= VMAX[31:0];
              e_bad  <= 1'b1;
              e_last <= 1'b0;
              ret    <= ST_NK;
              step   <= ST_EMIT;
            end else begin
              step <= ST_A1;
            end
          end else if (qp == 64'd0) begin
            // zero momentum: distance falls back to the flight length
            per  <= q3;
            step <= ST_IS;
          end else begin
            step <= ST_I1;
          end
        end
        ST_A1: begin
          if (arsp.done) begin
            step <= ST_A2;
          end
        end
        ST_A2: begin
          if (arsp.done) begin
            den  <= arsp.p[63:0];
            step <= ST_A3;
          end
        end
        ST_A3: begin
          if (arsp.done) begin
            step <= ST_A4;
          end
        end
        ST_A4: begin
          if (arsp.done) begin
            e_q    <= Q_DIRA;
            e_val  <= sat_val(dira_v);
            e_bad  <= 1'b0;
            e_last <= 1'b0;
            ret    <= ST_NK;
            step   <= ST_EMIT;
          end
        end
        ST_I1: begin
          if (arsp.done) begin
            step <= ST_I2;
          end
        end
        ST_I2: begin
          if (arsp.done) begin
            per  <= (arsp.p[63:0] >= q3) ? 64'd0 : (q3 - arsp.p[63:0]);
            step <= ST_IS;
          end
        end
        ST_IS: begin
          if (arsp.done) begin
            e_q    <= Q_DIRA + {1'b0, k};
            e_val  <= sat_mag(arsp.p[63:0]);
            e_bad  <= 1'b0;
            e_last <= (k == 3'd4);
            ret    <= (k == 3'd4) ? ST_IDLE : ST_NK;
            step   <= ST_EMIT;
          end
        end
        ST_NK: begin
          k    <= k + 3'd1;
          i    <= 2'd0;
          pos  <= 64'd0;
          ng   <= 64'd0;
          qp   <= 64'd0;
          step <= ST_MD;
        end
        ST_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            step      <= ret;
          end
        end
        default: begin
          step <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((step == ST_EMIT) && (!res.valid || res.ready)) begin
      res.quantity   <= e_q;
      res.value      <= e_val;
      res.bad_divide <= e_bad;
      res.last       <= e_last;
    end
  end

endmodule

[rtl/decay_vertex_geometry.sv]
// ----------------------------------------------------------------------------
// decay_vertex_geometry
// Flight geometry of a decay candidate from nine loaded 3-vectors.
//
//   channel  dir  payload                                        handshake
//   cmd      in   opcode, comp_x/y/z, vertex_valid/fake, has_cand  valid/ready
//   res      out  quantity, value, bad_divide, last                valid/ready
//
// A load item is written to the vector store as it is popped; a failed
// evaluate emits a single no-candidate result. A passing evaluate runs on
// the shared arithmetic unit, one multiply, divide or square root at a time.
// Reset clears control state; the vector store holds garbage until loaded.
// A two-entry queue lets the front take items while the back works; a full
// result register stalls the back until the result is taken.
// ----------------------------------------------------------------------------
module decay_vertex_geometry import dvg_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  dvg_cmd_if.sink  cmd,
  dvg_res_if.source res
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  dvg_cmd_t       q_in;
  dvg_cmd_t       q_head;
  dvg_arith_req_t areq;
  dvg_arith_rsp_t arsp;

  dvg_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  dvg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  dvg_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  dvg_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .areq    (areq),
    .arsp    (arsp),
    .res     (res)
  );

endmodule

[rtl/dvg_checker.sv]
// ----------------------------------------------------------------------------
// dvg_checker
// Port-level checks on the result channel of decay_vertex_geometry.
// ----------------------------------------------------------------------------
`include "decay_vertex_geometry_macros.svh"

module dvg_checker import dvg_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [3:0] res_quantity,
  input logic       res_bad_divide,
  input logic       res_last
);

  // a stalled result holds
  `DVG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_quantity))

  // only the error, pointing and division-based results can be flagged
  `DVG_ASSERT_IMPL(a_bad_kind, res_valid && res_bad_divide, (res_quantity == Q_DXY_ERR) || (res_quantity == Q_FD_ERR) || (res_quantity == Q_DIRA))

  // last marks the final distance or the no-candidate result
  `DVG_ASSERT_IMPL(a_last_kind, res_valid && res_last, (res_quantity == Q_IP_LAST) || (res_quantity == Q_NONE))

  // and those always close an evaluation
  `DVG_ASSERT_IMPL(a_last_set, res_valid && ((res_quantity == Q_IP_LAST) || (res_quantity == Q_NONE)), res_last)

endmodule

bind decay_vertex_geometry dvg_checker u_dvg_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_quantity   (res.quantity),
  .res_bad_divide (res.bad_divide),
  .res_last       (res.last)
);
